>>> hdl/direct_mapped_search_table_macros.svh
// assertion macros for the direct-mapped search table checker
// no dependencies; included by the checker file only
`ifndef DIRECT_MAPPED_SEARCH_TABLE_MACROS_SVH
`define DIRECT_MAPPED_SEARCH_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DMST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("search table check failed");

// next-cycle implication, disabled during reset
`define DMST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("search table check failed");

`endif

>>> hdl/dmst_pkg.sv
// shared types and codes for the direct-mapped search table
// no dependencies; used by the top level and the checker
package dmst_pkg;

    localparam logic [1:0] ACT_STORE = 2'd0;
    localparam logic [1:0] ACT_PROBE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [2:0] STS_EMPTY_STORE = 3'd0;
    localparam logic [2:0] STS_OVERWRITE   = 3'd1;
    localparam logic [2:0] STS_REJECTED    = 3'd2;
    localparam logic [2:0] STS_PROBE_EMPTY = 3'd3;
    localparam logic [2:0] STS_HIT         = 3'd4;
    localparam logic [2:0] STS_COLLISION   = 3'd5;
    localparam logic [2:0] STS_CLEARED     = 3'd6;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [7:0]  depth;
        logic [7:0]  age;
        logic [63:0] payload;
    } slot_t;

endpackage

>>> hdl/direct_mapped_search_table.sv
// direct-mapped search table: one single-port slot memory, read-modify-write per item
// depends on dmst_pkg
// store/probe: the accepting edge registers the slot read, then the EXEC state writes back and
//   registers the result strobe; a new item is taken only once the block is back in idle
// clear: sweeps every slot, then strobes the result
// reset: busy for a sweep that empties every slot; results cannot be stalled
module direct_mapped_search_table
    import dmst_pkg::*;
#(
    parameter int ENTRIES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [63:0] entry_key,
    input  logic [7:0]  entry_depth,
    input  logic [7:0]  entry_age,
    input  logic [63:0] entry_payload,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  found_depth,
    output logic [7:0]  found_age,
    output logic [63:0] found_payload,
    output logic [10:0] populated_entries
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(ENTRIES - 1);

    localparam logic [1:0] S_SWEEP = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          clr_reg, clr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    logic [2:0]    status_reg, status_next;
    logic [7:0]    fdepth_reg, fdepth_next;
    logic [7:0]    fage_reg, fage_next;
    logic [63:0]   fpay_reg, fpay_next;

    logic [1:0]    act_reg;
    logic [63:0]   key_reg;
    logic [7:0]    depth_reg;
    logic [7:0]    age_reg;
    logic [63:0]   pay_reg;

    slot_t         mem [ENTRIES];
    slot_t         rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    slot_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic          accept;
    logic          was_filled;
    logic          key_match;
    logic          age_old;
    logic [CW+10:0] count_ext;

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign mem_re     = accept;
    assign mem_raddr  = entry_key[AW-1:0];

    assign was_filled = rd_data_reg.valid && (rd_data_reg.key != 64'd0);
    assign key_match  = (rd_data_reg.key == key_reg);
    assign age_old    = (({1'b0, rd_data_reg.age} + 9'd2) < {1'b0, age_reg});

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        fdepth_next = 8'd0;
        fage_next   = 8'd0;
        fpay_next   = 64'd0;
        mem_we      = 1'b0;
        mem_waddr   = sweep_reg;
        mem_wdata   = '0;

        unique case (state_reg)
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                if (sweep_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                    sweep_next = '0;
                    if (clr_reg)
                    begin
                        clr_next    = 1'b0;
                        done_next   = 1'b1;
                        status_next = STS_CLEARED;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_CLEAR)
                    begin
                        state_next = S_SWEEP;
                        sweep_next = '0;
                        clr_next   = 1'b1;
                        count_next = '0;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                state_next        = S_IDLE;
                done_next         = 1'b1;
                mem_waddr         = key_reg[AW-1:0];
                mem_wdata.valid   = 1'b1;
                mem_wdata.key     = key_reg;
                mem_wdata.depth   = depth_reg;
                mem_wdata.age     = age_reg;
                mem_wdata.payload = pay_reg;
                case (act_reg) inside
                    ACT_STORE:
                    begin
                        if (!was_filled)
                        begin
                            status_next = STS_EMPTY_STORE;
                            mem_we      = 1'b1;
                            if (key_reg != 64'd0)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        else if (key_match || (depth_reg >= rd_data_reg.depth) || age_old)
                        begin
                            status_next = STS_OVERWRITE;
                            mem_we      = 1'b1;
                            if (key_reg == 64'd0)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        else
                        begin
                            status_next = STS_REJECTED;
                        end
                    end
                    ACT_PROBE, ACT_SPARE:
                    begin
                        if (!was_filled)
                        begin
                            status_next = STS_PROBE_EMPTY;
                        end
                        else if (key_match)
                        begin
                            status_next = STS_HIT;
                            fdepth_next = rd_data_reg.depth;
                            fage_next   = rd_data_reg.age;
                            fpay_next   = rd_data_reg.payload;
                        end
                        else
                        begin
                            status_next = STS_COLLISION;
                        end
                    end
                    default:
                    begin
                        status_next = STS_CLEARED;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            sweep_reg <= '0;
            clr_reg   <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        fdepth_reg <= fdepth_next;
        fage_reg   <= fage_next;
        fpay_reg   <= fpay_next;
        if (accept)
        begin
            act_reg   <= action;
            key_reg   <= entry_key;
            depth_reg <= entry_depth;
            age_reg   <= entry_age;
            pay_reg   <= entry_payload;
        end
    end

    assign count_ext         = {11'd0, count_reg};
    assign done              = done_reg;
    assign status            = status_reg;
    assign found_depth       = fdepth_reg;
    assign found_age         = fage_reg;
    assign found_payload     = fpay_reg;
    assign populated_entries = count_ext[10:0];

endmodule

>>> hdl/dmst_checker.sv
// port-level checker for the direct-mapped search table, bound to the top level
// depends on dmst_pkg and direct_mapped_search_table_macros.svh
`include "direct_mapped_search_table_macros.svh"

module dmst_checker
    import dmst_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [7:0]  found_depth,
    input logic [7:0]  found_age,
    input logic [63:0] found_payload,
    input logic [10:0] populated_entries
);

    logic found_zero;

    assign found_zero = (found_depth == 8'd0) && (found_age == 8'd0)
                        && (found_payload == 64'd0);

    // an accepted transfer keeps the block busy in the next cycle
    `DMST_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // a result always follows a busy cycle
    `DMST_ASSERT_IMP(a_done_after_busy, clk, rst_n, done, $past(busy))

    // found fields are zero unless the result is a hit
    `DMST_ASSERT_IMP(a_miss_zero, clk, rst_n, done && (status != STS_HIT), found_zero)

    // a clear leaves no occupied slots
    `DMST_ASSERT_IMP(a_clear_count, clk, rst_n, done && (status == STS_CLEARED), populated_entries == 11'd0)

endmodule

bind direct_mapped_search_table dmst_checker u_dmst_checker (.*);

>>> bench/direct_mapped_search_table_tb.sv
`timescale 1ns / 1ps
// self-checking bench for direct_mapped_search_table: directed and random store/probe/clear
// depends on dmst_pkg and the direct_mapped_search_table rtl
module direct_mapped_search_table_tb;
    import dmst_pkg::*;

    localparam int TABLE_SLOTS    = 1024;
    localparam int RANDOM_ITEMS   = 1830;
    localparam int WATCHDOG_LIMIT = 4 * (TABLE_SLOTS + 2) + 1000;

    typedef struct {
        logic [1:0]  action;
        logic [63:0] key;
        logic [7:0]  depth;
        logic [7:0]  age;
        logic [63:0] payload;
        int          idle_pct;
        bit          wait_drained;
    } table_command_t;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  depth;
        logic [7:0]  age;
        logic [63:0] payload;
        logic [10:0] count;
    } table_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [63:0] entry_key;
    logic [7:0]  entry_depth;
    logic [7:0]  entry_age;
    logic [63:0] entry_payload;
    logic        done;
    logic [2:0]  status;
    logic [7:0]  found_depth;
    logic [7:0]  found_age;
    logic [63:0] found_payload;
    logic [10:0] populated_entries;

    table_command_t command_queue[$];
    table_result_t  expected_results[$];

    bit          tbl_valid [TABLE_SLOTS];
    logic [63:0] tbl_key [TABLE_SLOTS];
    logic [7:0]  tbl_depth [TABLE_SLOTS];
    logic [7:0]  tbl_age [TABLE_SLOTS];
    logic [63:0] tbl_payload [TABLE_SLOTS];
    int          tbl_occupied = 0;

    int unsigned transfers_in = 0;
    int unsigned results_out = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;

    direct_mapped_search_table #(.ENTRIES(TABLE_SLOTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .entry_key(entry_key),
        .entry_depth(entry_depth),
        .entry_age(entry_age),
        .entry_payload(entry_payload),
        .done(done),
        .status(status),
        .found_depth(found_depth),
        .found_age(found_age),
        .found_payload(found_payload),
        .populated_entries(populated_entries)
    );

    always #4 clk = ~clk;

    function automatic table_result_t predict_table_access(table_command_t cmd);
        table_result_t res;
        int  idx;
        bit  was_filled;
        bit  take;
        idx = int'(cmd.key[9:0]);
        res = '{status: STS_CLEARED, depth: 8'd0, age: 8'd0, payload: 64'd0, count: 11'd0};
        was_filled = tbl_valid[idx] && tbl_key[idx] != 64'd0;
        if (cmd.action == ACT_CLEAR)
        begin
            foreach (tbl_valid[i])
                tbl_valid[i] = 1'b0;
            tbl_occupied = 0;
            res.status = STS_CLEARED;
        end
        else if (cmd.action == ACT_STORE)
        begin
            take = 1'b1;
            if (!was_filled)
                res.status = STS_EMPTY_STORE;
            else if (tbl_key[idx] == cmd.key || cmd.depth >= tbl_depth[idx]
                     || int'(tbl_age[idx]) + 2 < int'(cmd.age))
                res.status = STS_OVERWRITE;
            else
            begin
                res.status = STS_REJECTED;
                take = 1'b0;
            end
            if (take)
            begin
                tbl_valid[idx] = 1'b1;
                tbl_key[idx] = cmd.key;
                tbl_depth[idx] = cmd.depth;
                tbl_age[idx] = cmd.age;
                tbl_payload[idx] = cmd.payload;
                if (was_filled && cmd.key == 64'd0)
                    tbl_occupied--;
                else if (!was_filled && cmd.key != 64'd0)
                    tbl_occupied++;
            end
        end
        else
        begin
            if (!was_filled)
                res.status = STS_PROBE_EMPTY;
            else if (tbl_key[idx] == cmd.key)
            begin
                res.status = STS_HIT;
                res.depth = tbl_depth[idx];
                res.age = tbl_age[idx];
                res.payload = tbl_payload[idx];
            end
            else
                res.status = STS_COLLISION;
        end
        res.count = tbl_occupied[10:0];
        return res;
    endfunction

    // driver: present the next command once the current one has been transferred
    always @(posedge clk or negedge rst_n)
    begin
        table_command_t cmd;
        bit             took;
        int unsigned    outstanding;
        if (!rst_n)
        begin
            start <= 1'b0;
            action <= ACT_STORE;
            entry_key <= 64'd0;
            entry_depth <= 8'd0;
            entry_age <= 8'd0;
            entry_payload <= 64'd0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                cmd.action = action;
                cmd.key = entry_key;
                cmd.depth = entry_depth;
                cmd.age = entry_age;
                cmd.payload = entry_payload;
                expected_results.push_back(predict_table_access(cmd));
                transfers_in <= transfers_in + 1;
            end
            if (!start || took)
            begin
                outstanding = transfers_in + 32'(took) - results_out - 32'(done);
                if (command_queue.size() != 0
                    && !(command_queue[0].wait_drained && outstanding != 0)
                    && $urandom_range(99) >= command_queue[0].idle_pct)
                begin
                    cmd = command_queue.pop_front();
                    start <= 1'b1;
                    action <= cmd.action;
                    entry_key <= cmd.key;
                    entry_depth <= cmd.depth;
                    entry_age <= cmd.age;
                    entry_payload <= cmd.payload;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic show_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
        mismatches++;
    endtask

    // monitor: every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && done)
        begin
            results_out <= results_out + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none actual status %0d",
                         $time, status);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    show_mismatch("status", 64'(want.status), 64'(status));
                if (found_depth !== want.depth)
                    show_mismatch("found_depth", 64'(want.depth), 64'(found_depth));
                if (found_age !== want.age)
                    show_mismatch("found_age", 64'(want.age), 64'(found_age));
                if (found_payload !== want.payload)
                    show_mismatch("found_payload", want.payload, found_payload);
                if (populated_entries !== want.count)
                    show_mismatch("populated_entries", 64'(want.count),
                                  64'(populated_entries));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic add_command(logic [1:0] act, logic [63:0] key, logic [7:0] depth,
                               logic [7:0] age, logic [63:0] payload, int idle_pct,
                               bit wait_drained);
        table_command_t cmd;
        cmd = '{action: act, key: key, depth: depth, age: age, payload: payload,
                idle_pct: idle_pct, wait_drained: wait_drained};
        command_queue.push_back(cmd);
    endtask

    function automatic logic [63:0] key_for_slot(int unsigned slot);
        logic [63:0] key;
        key = {$urandom, $urandom};
        key[9:0] = slot[9:0];
        return key;
    endfunction

    initial
    begin
        int unsigned hot_slots [16];
        logic [63:0] key_pool[$];
        int          phase_idle [3];
        int          pick;
        int          kind;
        int unsigned slot;
        logic [63:0] key;
        logic [1:0]  act;
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;

        phase_idle = '{0, 86, 20};
        foreach (hot_slots[i])
            hot_slots[i] = $urandom_range(TABLE_SLOTS - 1);

        k1 = 64'hFFFF_FFFF_FFFF_FC05;
        k2 = 64'h8000_0000_0000_0005;
        k3 = 64'h1234_5678_9ABC_DC05;
        add_command(ACT_PROBE, 64'd0, 8'd0, 8'd0, 64'd0, 0, 1'b0);
        add_command(ACT_STORE, 64'd0, 8'd3, 8'd1, 64'h5555_5555_5555_5555, 0, 1'b0);
        add_command(ACT_PROBE, 64'd0, 8'd0, 8'd0, 64'd0, 0, 1'b0);
        add_command(ACT_STORE, k1, 8'hFF, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
        add_command(ACT_PROBE, k1, 8'd0, 8'd0, 64'd0, 0, 1'b0);
        // depth and age both too low
        add_command(ACT_STORE, k2, 8'd10, 8'd2, 64'h1, 0, 1'b0);
        // age beyond stored age plus two
        add_command(ACT_STORE, k2, 8'd10, 8'd3, 64'h2, 0, 1'b0);
        add_command(ACT_PROBE, k1, 8'd0, 8'd0, 64'd0, 0, 1'b0);
        add_command(ACT_STORE, k3, 8'd9, 8'd5, 64'h3, 0, 1'b0);
        // equal depth wins
        add_command(ACT_STORE, k3, 8'd10, 8'd0, 64'h4, 0, 1'b0);
        // same key always wins
        add_command(ACT_STORE, k3, 8'd0, 8'd0, 64'h0, 0, 1'b0);
        add_command(ACT_PROBE, k3, 8'd0, 8'd0, 64'd0, 0, 1'b0);
        // zero key overwriting an occupied slot empties it
        add_command(ACT_STORE, 64'h400, 8'd0, 8'd0, 64'hA5, 0, 1'b0);
        add_command(ACT_STORE, 64'd0, 8'd0, 8'd0, 64'h5A, 0, 1'b0);
        add_command(ACT_PROBE, 64'd0, 8'd0, 8'd0, 64'd0, 0, 1'b0);
        add_command(ACT_STORE, 64'd0, 8'd0, 8'd0, 64'h5A, 0, 1'b0);
        // age near the top, no wrap
        add_command(ACT_STORE, 64'hAAAA_0000_0000_0007, 8'd200, 8'd253, 64'h7, 0, 1'b0);
        add_command(ACT_STORE, 64'h5555_0000_0000_0007, 8'd0, 8'd255, 64'h8, 0, 1'b0);
        add_command(ACT_STORE, 64'hAAAA_0000_0000_0009, 8'd200, 8'd252, 64'h9, 0, 1'b0);
        add_command(ACT_STORE, 64'h5555_0000_0000_0009, 8'd0, 8'd255, 64'hA, 0, 1'b0);
        add_command(ACT_SPARE, k3, 8'd0, 8'd0, 64'd0, 0, 1'b0);
        add_command(ACT_CLEAR, 64'd0, 8'd0, 8'd0, 64'd0, 0, 1'b0);
        add_command(ACT_PROBE, k3, 8'd0, 8'd0, 64'd0, 0, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            kind = $urandom_range(99);
            if (key_pool.size() != 0 && kind < 50)
                key = key_pool[$urandom_range(key_pool.size() - 1)];
            else if (kind < 53)
                key = 64'd0;
            else
            begin
                if ($urandom_range(3) == 0)
                    slot = $urandom_range(TABLE_SLOTS - 1);
                else
                    slot = hot_slots[$urandom_range(15)];
                key = key_for_slot(slot);
            end
            if (pick < 1)
                act = ACT_CLEAR;
            else if (pick < 46)
            begin
                act = ACT_STORE;
                key_pool.push_back(key);
                if (key_pool.size() > 48)
                    void'(key_pool.pop_front());
            end
            else if ($urandom_range(19) == 0)
                act = ACT_SPARE;
            else
                act = ACT_PROBE;
            add_command(act, key, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                        phase_idle[(n / 150) % 3], (n % 400) == 0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (command_queue.size() != 0 || start)
            @(posedge clk);
        while (transfers_in != results_out)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: results still expected, expected %0d actual 0",
                     $time, expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/dmst_pkg.sv
hdl/direct_mapped_search_table.sv
hdl/dmst_checker.sv
bench/direct_mapped_search_table_tb.sv
